/* hw/rtl/msun_pkg.sv */
// Shared types and constants for the memory size unit normalizer.
package msun_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned FracW = 10;
  localparam int unsigned CountW = 16;
  localparam int unsigned UnitW = 2;

  localparam logic [WordW-1:0] FULL_RANGE = 32'hFFFF_FFFF;
  localparam logic [WordW-1:0] UNIT_STEP = 32'd1024;

  localparam logic [UnitW-1:0] UNIT_BYTE = 2'd0;
  localparam logic [UnitW-1:0] UNIT_KB = 2'd1;
  localparam logic [UnitW-1:0] UNIT_GB = 2'd3;

  // Request to the shared divider.
  typedef struct packed {
    logic             start;
    logic [WordW-1:0] dividend;
    logic [WordW-1:0] divisor;
  } div_req_t;

  // Result from the shared divider.
  typedef struct packed {
    logic             done;
    logic [WordW-1:0] quotient;
    logic [WordW-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LIMIT,
    ST_STEP,
    ST_KDIV,
    ST_MUL,
    ST_SCALE,
    ST_DONE
  } msun_state_t;

endpackage

/* hw/rtl/msun_div.sv */
// Restoring divider, one quotient bit per cycle, shared by all divisions.
module msun_div (
  input  logic               clk,
  input  logic               rst,
  input  msun_pkg::div_req_t req,
  output msun_pkg::div_rsp_t rsp
);
  import msun_pkg::*;

  localparam int unsigned CntW = $clog2(WordW);

  logic [WordW-1:0] rem;
  logic [WordW-1:0] quo;
  logic [WordW-1:0] dvs;
  logic [CntW-1:0]  cnt;
  logic             busy;
  logic             done;
  logic [WordW:0]   trial;

  // Trial subtraction of the held divisor from the shifted partial remainder.
  assign trial = {rem, quo[WordW-1]} - {1'b0, dvs};

  // Control: run for one cycle per quotient bit, then pulse done.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(WordW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: a divisor of zero yields an all-ones quotient.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quo <= req.dividend;
      dvs <= req.divisor;
    end else if (busy) begin
      if (!trial[WordW]) begin
        rem <= trial[WordW-1:0];
        quo <= {quo[WordW-2:0], 1'b1};
      end else begin
        rem <= {rem[WordW-2:0], quo[WordW-1]};
        quo <= {quo[WordW-2:0], 1'b0};
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quotient = quo;
  assign rsp.remainder = rem;

endmodule

/* hw/rtl/mem_size_unit_normalizer.sv */
// Memory size unit normalizer: top level with sequencer, multiply and scaling steps.
// The shared divider runs once when the value is taken in bytes or by multiplication and
// three times when the count is divided down to kilobytes. One word at a time: start is
// taken in the cycle after the result, and the receiver cannot stall. Reset (rst,
// synchronous) idles all.
module mem_size_unit_normalizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] block_count,
  input  logic [31:0] block_size,
  output logic        done,
  output logic [1:0]  size_unit,
  output logic [15:0] unit_count,
  output logic [9:0]  unit_fraction
);
  import msun_pkg::*;

  localparam int unsigned QW = WordW - FracW;

  msun_state_t state, state_next;
  div_req_t    dreq;
  div_rsp_t    drsp;

  logic [WordW-1:0]  cnt;
  logic [WordW-1:0]  size;
  logic [WordW-1:0]  mul_op;
  logic [QW-1:0]     q;
  logic [FracW-1:0]  f;
  logic [UnitW-1:0]  unit;
  logic [CountW-1:0] res_cnt;
  logic [FracW-1:0]  res_frac;
  logic [WordW-1:0]  product;
  logic              load_val;
  logic [WordW-1:0]  load_data;
  logic [FracW-1:0]  load_frac;

  msun_div u_div (
    .clk(clk),
    .rst(rst),
    .req(dreq),
    .rsp(drsp)
  );

  // Low half of the product; the kilobyte path wraps at 32 bits.
  assign product = cnt * mul_op;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, divider requests and value loads.
  always_comb begin
    state_next = state;
    dreq = '0;
    load_val = 1'b0;
    load_data = product;
    load_frac = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          dreq.start = 1'b1;
          dreq.dividend = FULL_RANGE;
          dreq.divisor = block_size;
          state_next = ST_LIMIT;
        end
      end
      ST_LIMIT: begin
        if (drsp.done) begin
          if (cnt > drsp.quotient && size < UNIT_STEP) begin
            dreq.start = 1'b1;
            dreq.dividend = UNIT_STEP;
            dreq.divisor = size;
            state_next = ST_STEP;
          end else begin
            state_next = ST_MUL;
          end
        end
      end
      ST_STEP: begin
        if (drsp.done) begin
          dreq.start = 1'b1;
          dreq.dividend = cnt;
          dreq.divisor = drsp.quotient;
          state_next = ST_KDIV;
        end
      end
      ST_KDIV: begin
        if (drsp.done) begin
          load_val = 1'b1;
          load_data = drsp.quotient;
          load_frac = drsp.remainder[FracW-1:0];
          state_next = ST_SCALE;
        end
      end
      ST_MUL: begin
        load_val = 1'b1;
        state_next = ST_SCALE;
      end
      ST_SCALE: begin
        if (q == '0 || unit == UNIT_GB || q < QW'(UNIT_STEP)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Operand capture and unit choice after the limit is known.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      cnt <= block_count;
      size <= block_size;
    end
    if (state == ST_LIMIT && drsp.done) begin
      if (cnt > drsp.quotient) begin
        unit <= UNIT_KB;
        mul_op <= {{FracW{1'b0}}, size[WordW-1:FracW]};
      end else begin
        unit <= UNIT_BYTE;
        mul_op <= size;
      end
    end
    // Load the starting value; the fallback result is the unscaled value.
    if (load_val) begin
      q <= load_data[WordW-1:FracW];
      f <= load_data[FracW-1:0];
      res_cnt <= load_data[CountW-1:0];
      res_frac <= load_frac;
    end
    // One scaling step by 1024 per cycle until the count fits, stopping at gigabytes.
    if (state == ST_SCALE && q != '0 && unit != UNIT_GB) begin
      unit <= unit + 1'b1;
      if (q < QW'(UNIT_STEP)) begin
        res_cnt <= q[CountW-1:0];
        res_frac <= f;
      end else begin
        f <= q[FracW-1:0];
        q <= {{FracW{1'b0}}, q[QW-1:FracW]};
      end
    end
  end

  // Outputs.
  assign busy = (state != ST_IDLE);
  assign done = (state == ST_DONE);
  assign size_unit = unit;
  assign unit_count = res_cnt;
  assign unit_fraction = res_frac;

endmodule

/* verif/mem_size_unit_normalizer_test.sv */
// Self-checking testbench for the memory size unit normalizer with a built-in predictor.
`timescale 1ns / 100ps

module mem_size_unit_normalizer_test;
  import msun_pkg::*;

  localparam int unsigned StallLimit = 5000;
  localparam int unsigned DrainCycles = 120;
  localparam int NumDirected = 21;

  // One result word as the block presents it.
  typedef struct packed {
    logic [UnitW-1:0]  size_unit;
    logic [CountW-1:0] unit_count;
    logic [FracW-1:0]  unit_fraction;
  } size_word_t;

  // One row of the directed table; known rows carry a hand-computed answer.
  typedef struct packed {
    logic [WordW-1:0]  count;
    logic [WordW-1:0]  size;
    logic              known;
    logic [UnitW-1:0]  exp_unit;
    logic [CountW-1:0] exp_count;
    logic [FracW-1:0]  exp_frac;
  } size_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] block_count = '0;
  logic [31:0] block_size = 32'd1;
  logic        done;
  logic [1:0]  size_unit;
  logic [15:0] unit_count;
  logic [9:0]  unit_fraction;

  size_word_t  pending_sizes[$];
  int unsigned mismatches = 0;
  int unsigned stall_cycles = 0;

  size_row_t directed_rows [NumDirected] = '{
    '{32'h0000_0000, 32'h0000_0001, 1'b1, UNIT_BYTE, 16'd0,    10'd0},
    '{32'h0000_0001, 32'h0000_0001, 1'b1, UNIT_BYTE, 16'd1,    10'd0},
    '{32'h0000_03FF, 32'h0000_0001, 1'b1, UNIT_BYTE, 16'd1023, 10'd0},
    '{32'h0000_0400, 32'h0000_0001, 1'b1, UNIT_KB,   16'd1,    10'd0},
    '{32'h0000_0000, 32'h0000_0000, 1'b1, UNIT_BYTE, 16'd0,    10'd0},
    '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, UNIT_BYTE, 16'd0,    10'd0},
    '{32'h0000_0001, 32'h4000_0000, 1'b1, UNIT_GB,   16'd1,    10'd0},
    '{32'hFFFF_FFFF, 32'h0000_0001, 1'b0, UNIT_BYTE, 16'd0,    10'd0},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, UNIT_BYTE, 16'd0,    10'd0},
    '{32'h0000_0001, 32'hFFFF_FFFF, 1'b0, UNIT_BYTE, 16'd0,    10'd0},
    '{32'hFFFF_FFFF, 32'h0000_03FF, 1'b0, UNIT_BYTE, 16'd0,    10'd0},
    '{32'hFFFF_FFFF, 32'h0000_0200, 1'b0, UNIT_BYTE, 16'd0,    10'd0},
    '{32'hFFFF_FFFF, 32'h0000_0003, 1'b0, UNIT_BYTE, 16'd0,    10'd0},
    '{32'h003F_FFFF, 32'h0000_0400, 1'b0, UNIT_BYTE, 16'd0,    10'd0},
    '{32'h0040_0000, 32'h0000_0400, 1'b0, UNIT_BYTE, 16'd0,    10'd0},
    '{32'h0000_0002, 32'h8000_0000, 1'b0, UNIT_BYTE, 16'd0,    10'd0},
    '{32'h0000_0001, 32'h0018_0000, 1'b0, UNIT_BYTE, 16'd0,    10'd0},
    '{32'h0000_5555, 32'h0000_AAAA, 1'b0, UNIT_BYTE, 16'd0,    10'd0},
    '{32'hAAAA_AAAA, 32'h0000_0002, 1'b0, UNIT_BYTE, 16'd0,    10'd0},
    '{32'h1234_5678, 32'h0000_03E8, 1'b0, UNIT_BYTE, 16'd0,    10'd0},
    '{32'h0000_0001, 32'h0000_0003, 1'b0, UNIT_BYTE, 16'd0,    10'd0}
  };

  mem_size_unit_normalizer dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .block_count   (block_count),
    .block_size    (block_size),
    .done          (done),
    .size_unit     (size_unit),
    .unit_count    (unit_count),
    .unit_fraction (unit_fraction)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Expected unit, count and fraction for a block count of a given block size.
  function automatic size_word_t normalize_size(input logic [31:0] cnt,
                                                input logic [31:0] sz);
    logic [31:0] limit;
    logic [31:0] val;
    logic [31:0] step_div;
    logic [31:0] frac;
    logic [31:0] q;
    logic [31:0] rem;
    logic [1:0]  scale;
    logic        stopped;
    size_word_t  w;
    limit = (sz != 32'd0) ? FULL_RANGE / sz : FULL_RANGE;
    rem = 32'd0;
    if (cnt > limit) begin
      // Too large for bytes: go straight to kilobytes.
      scale = UNIT_KB;
      if (sz < UNIT_STEP) begin
        step_div = UNIT_STEP / sz;
        rem = cnt % step_div;
        val = cnt / step_div;
      end else begin
        val = cnt * (sz / UNIT_STEP);
      end
    end else begin
      scale = UNIT_BYTE;
      val = cnt * sz;
    end
    // Scale down by 1024 until the count fits or gigabytes are reached.
    frac = val % UNIT_STEP;
    q = val / UNIT_STEP;
    stopped = 1'b0;
    while (q != 32'd0 && scale < UNIT_GB && !stopped) begin
      scale = scale + 2'd1;
      if (q < UNIT_STEP) begin
        rem = frac;
        val = q;
        stopped = 1'b1;
      end else begin
        frac = q % UNIT_STEP;
        q = q / UNIT_STEP;
      end
    end
    w.size_unit = scale;
    w.unit_count = val[15:0];
    w.unit_fraction = rem[9:0];
    return w;
  endfunction

  // Block sizes weighted toward the interesting classes.
  function automatic logic [31:0] pick_block_size();
    logic [31:0] sz;
    case ($urandom_range(5))
      0: sz = $urandom_range(1, 1023);
      1: sz = 32'h1 << $urandom_range(31);
      2: sz = $urandom_range(1, 32'h3F_FFFF) << 10;
      3: sz = $urandom();
      4: sz = $urandom_range(1, 65535);
      default: sz = 32'hFFFF_FFFF - $urandom_range(0, 1023);
    endcase
    if (sz == 32'd0) sz = 32'd1;
    return sz;
  endfunction

  // Block counts spread over both paths and the boundary between them.
  function automatic logic [31:0] pick_block_count(input logic [31:0] sz);
    logic [31:0] limit;
    logic [31:0] cnt;
    limit = FULL_RANGE / sz;
    case ($urandom_range(4))
      0: cnt = $urandom();
      1: cnt = $urandom_range(0, 1023);
      2: cnt = limit - 32'd1 + $urandom_range(2);
      3: cnt = $urandom_range(0, limit);
      default: cnt = $urandom_range(limit, 32'hFFFF_FFFF);
    endcase
    return cnt;
  endfunction

  // Offer one word, holding start low on idle cycles, until it is taken.
  task automatic send_word(input logic [31:0] cnt, input logic [31:0] sz,
                           input size_word_t expected, input int unsigned idle_pct);
    logic taken;
    taken = 1'b0;
    block_count <= cnt;
    block_size <= sz;
    while (!taken) begin
      if ($urandom_range(99) < idle_pct) start <= 1'b0;
      else start <= 1'b1;
      @(posedge clk);
      taken = start && !busy;
    end
    pending_sizes.push_back(expected);
  endtask

  // Compare each result word against the oldest expected one.
  always @(posedge clk) begin
    size_word_t exp_word;
    if (!rst && done) begin
      if (pending_sizes.size() == 0) begin
        $display("%0t: unexpected word expected none actual unit %0d count %0d fraction %0d",
                 $time, size_unit, unit_count, unit_fraction);
        mismatches++;
      end else begin
        exp_word = pending_sizes.pop_front();
        if (size_unit !== exp_word.size_unit) begin
          $display("%0t: size_unit expected %0d actual %0d",
                   $time, exp_word.size_unit, size_unit);
          mismatches++;
        end
        if (unit_count !== exp_word.unit_count) begin
          $display("%0t: unit_count expected %0d actual %0d",
                   $time, exp_word.unit_count, unit_count);
          mismatches++;
        end
        if (unit_fraction !== exp_word.unit_fraction) begin
          $display("%0t: unit_fraction expected %0d actual %0d",
                   $time, exp_word.unit_fraction, unit_fraction);
          mismatches++;
        end
      end
    end
  end

  // End the run when nothing moves in either direction for too long.
  always @(posedge clk) begin
    if ((start && !busy) || done) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles == StallLimit) begin
      $display("mem_size_unit_normalizer_test: FAIL");
      $finish;
    end
  end

  initial begin
    size_word_t  exp_word;
    logic [31:0] cnt;
    logic [31:0] sz;
    int unsigned idle_pct;
    int unsigned num_words;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: extremes, both paths and the corner cases.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].known) begin
        exp_word.size_unit = directed_rows[i].exp_unit;
        exp_word.unit_count = directed_rows[i].exp_count;
        exp_word.unit_fraction = directed_rows[i].exp_frac;
      end else begin
        exp_word = normalize_size(directed_rows[i].count, directed_rows[i].size);
      end
      send_word(directed_rows[i].count, directed_rows[i].size, exp_word, 20);
    end

    // Random words in three phases of sender idling.
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 20 : (phase == 1) ? 55 : 0;
      num_words = (phase == 2) ? 600 : 700;
      for (int n = 0; n < num_words; n++) begin
        sz = pick_block_size();
        cnt = pick_block_count(sz);
        send_word(cnt, sz, normalize_size(cnt, sz), idle_pct);
      end
    end
    start <= 1'b0;

    // Drain outstanding words, then allow for a late extra one.
    while (pending_sizes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatches == 0) begin
      $display("mem_size_unit_normalizer_test: PASS");
    end else begin
      $display("mem_size_unit_normalizer_test: FAIL");
    end
    $finish;
  end

endmodule
